// File: hw/rtl/lsp_pkg.sv
// Package: shared types, constants and functions of the light style pattern player.
`timescale 1ns / 1ps

package lsp_pkg;

  // Default sizes of the style tables.
  localparam int NUM_STYLES      = 64;
  localparam int MAX_PATTERN_LEN = 64;

  // Field widths of the word ports.
  localparam int FUNC_W   = 2;
  localparam int SIDX_W   = 8;
  localparam int POS_W    = 6;
  localparam int CHAR_W   = 8;
  localparam int LEN_W    = 7;
  localparam int FRAME_W  = 32;
  localparam int LEVEL_W  = 5;
  localparam int WEIGHT_W = 7;
  localparam int ACTIVE_W = 7;

  // Frame modulo length: this many quotient bits are resolved per cycle.
  localparam int DIV_BITS  = 4;
  localparam int DIV_STEPS = FRAME_W / DIV_BITS;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  // Letter range and drive weight constants.
  localparam logic [CHAR_W-1:0]   LETTER_LO   = 8'd97;   // 'a'
  localparam logic [CHAR_W-1:0]   LETTER_HI   = 8'd122;  // 'z'
  localparam logic [CHAR_W-1:0]   ASCII_TOP   = 8'd127;
  localparam logic [LEVEL_W-1:0]  FULL_LEVEL  = 5'd25;
  localparam logic [WEIGHT_W-1:0] WEIGHT_BASE = 7'd25;
  localparam logic [WEIGHT_W-1:0] WEIGHT_STEP = 7'd3;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_WRITE  = 2'd0,
    FUNC_LENGTH = 2'd1,
    FUNC_FRAME  = 2'd2,
    FUNC_QUERY  = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_LEN,
    ST_DIV,
    ST_RD,
    ST_FIN,
    ST_FULL
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic store_we;
    logic len_we;
    logic frame_we;
    logic div_start;
    logic div_step;
    logic res_load;
    logic res_full;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    func_e func;
    logic  sidx_ok;
    logic  pos_ok;
    logic  plen_zero;
    logic  div_last;
    logic  out_free;
  } status_t;

  // Pattern byte to brightness level. Bytes of 128 and above are negative
  // as signed characters and so fall below 'a'.
  function automatic logic [LEVEL_W-1:0] letter_level(input logic [CHAR_W-1:0] b);
    logic [CHAR_W-1:0] diff;
    diff = b - LETTER_LO;
    if (b inside {[LETTER_LO:LETTER_HI]}) begin
      return diff[LEVEL_W-1:0];
    end else if (b inside {[LETTER_HI + 8'd1:ASCII_TOP]}) begin
      return FULL_LEVEL;
    end else begin
      return '0;
    end
  endfunction

  // Drive weight in hundredths: 25 + 3 * level.
  function automatic logic [WEIGHT_W-1:0] level_weight(input logic [LEVEL_W-1:0] lvl);
    return WEIGHT_BASE + WEIGHT_STEP * WEIGHT_W'(lvl);
  endfunction

endpackage

// File: hw/rtl/lsp_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps

module lsp_ram #(
  parameter int Width = 8,
  parameter int Depth = 64,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/lsp_ctrl.sv
// Controller state machine: sequences each input word through the datapath.
`timescale 1ns / 1ps

module lsp_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  lsp_pkg::status_t  stat_i,
  output lsp_pkg::cmd_t     cmd_o
);

  lsp_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lsp_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      lsp_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = lsp_pkg::ST_EXEC;
      end
      lsp_pkg::ST_EXEC: begin
        if (stat_i.func == lsp_pkg::FUNC_QUERY) begin
          state_d = stat_i.sidx_ok ? lsp_pkg::ST_LEN : lsp_pkg::ST_FULL;
        end else begin
          state_d = lsp_pkg::ST_IDLE;
        end
      end
      lsp_pkg::ST_LEN: begin
        state_d = stat_i.plen_zero ? lsp_pkg::ST_FULL : lsp_pkg::ST_DIV;
      end
      lsp_pkg::ST_DIV: begin
        if (stat_i.div_last) state_d = lsp_pkg::ST_RD;
      end
      lsp_pkg::ST_RD: begin
        state_d = lsp_pkg::ST_FIN;
      end
      lsp_pkg::ST_FIN, lsp_pkg::ST_FULL: begin
        if (stat_i.out_free) state_d = lsp_pkg::ST_IDLE;
      end
      default: state_d = lsp_pkg::ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      lsp_pkg::ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      lsp_pkg::ST_EXEC: begin
        cmd_o.store_we = (stat_i.func == lsp_pkg::FUNC_WRITE) && stat_i.sidx_ok
                         && stat_i.pos_ok;
        cmd_o.len_we   = (stat_i.func == lsp_pkg::FUNC_LENGTH) && stat_i.sidx_ok;
        cmd_o.frame_we = (stat_i.func == lsp_pkg::FUNC_FRAME);
      end
      lsp_pkg::ST_LEN: begin
        cmd_o.div_start = 1'b1;
      end
      lsp_pkg::ST_DIV: begin
        cmd_o.div_step = 1'b1;
      end
      lsp_pkg::ST_FIN: begin
        cmd_o.res_load = stat_i.out_free;
      end
      lsp_pkg::ST_FULL: begin
        cmd_o.res_load = stat_i.out_free;
        cmd_o.res_full = 1'b1;
      end
      default: ;
    endcase
  end

endmodule

// File: hw/rtl/lsp_datapath.sv
// Datapath: style tables, frame register, modulo unit and output register.
`timescale 1ns / 1ps

module lsp_datapath #(
  parameter int NumStyles     = lsp_pkg::NUM_STYLES,
  parameter int MaxPatternLen = lsp_pkg::MAX_PATTERN_LEN
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [lsp_pkg::FUNC_W-1:0]     func_i,
  input  logic [lsp_pkg::SIDX_W-1:0]     style_index_i,
  input  logic [lsp_pkg::POS_W-1:0]      char_pos_i,
  input  logic [lsp_pkg::CHAR_W-1:0]     pattern_char_i,
  input  logic [lsp_pkg::LEN_W-1:0]      pattern_length_i,
  input  logic [lsp_pkg::FRAME_W-1:0]    frame_count_i,
  input  lsp_pkg::cmd_t                  cmd_i,
  output lsp_pkg::status_t               stat_o,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [lsp_pkg::LEVEL_W-1:0]    style_level_o,
  output logic [lsp_pkg::WEIGHT_W-1:0]   style_weight_o,
  output logic [lsp_pkg::ACTIVE_W-1:0]   active_styles_o
);

  localparam int SIW = (NumStyles > 1) ? $clog2(NumStyles) : 1;
  localparam int LW  = $clog2(MaxPatternLen + 1);
  localparam int CW  = $clog2(NumStyles + 1);
  localparam int AW  = $clog2(NumStyles * MaxPatternLen);
  localparam int PRW = SIW + LW;
  localparam int CMW = 9;  // wide enough for any index and either parameter

  // Captured input word.
  lsp_pkg::func_e                func_q;
  logic [lsp_pkg::SIDX_W-1:0]    sidx_q;
  logic [lsp_pkg::POS_W-1:0]     pos_q;
  logic [lsp_pkg::CHAR_W-1:0]    chr_q;
  logic [lsp_pkg::LEN_W-1:0]     len_q;
  logic [lsp_pkg::FRAME_W-1:0]   fin_q;

  // Block state.
  logic [lsp_pkg::FRAME_W-1:0]   frame_q;
  logic [CW-1:0]                 count_q;
  logic [NumStyles-1:0]          lvalid_q;

  // Modulo unit.
  logic [LW-1:0]                 plen_q, plen_d;
  logic [LW-1:0]                 rem_q, rem_step;
  logic [lsp_pkg::FRAME_W-1:0]   shf_q, shf_step;
  logic [lsp_pkg::STEP_W-1:0]    step_q;

  // Output register.
  logic                          out_valid_q;
  logic [lsp_pkg::LEVEL_W-1:0]   level_q, level_d;
  logic [lsp_pkg::WEIGHT_W-1:0]  weight_q;
  logic [lsp_pkg::ACTIVE_W-1:0]  active_q;

  logic [SIW-1:0]                sidx_idx;
  logic                          sidx_ok, pos_ok, out_free;
  logic [PRW-1:0]                base;
  logic [AW-1:0]                 waddr, raddr;
  logic [LW-1:0]                 len_sat, len_rdata;
  logic [lsp_pkg::CHAR_W-1:0]    chr_rdata;

  assign sidx_idx = sidx_q[SIW-1:0];
  assign sidx_ok  = CMW'(sidx_q) < CMW'(NumStyles);
  assign pos_ok   = CMW'(pos_q) < CMW'(MaxPatternLen);
  assign out_free = !out_valid_q || out_ready_i;

  // Row base of the style in the pattern store.
  assign base  = PRW'(sidx_idx) * PRW'(MaxPatternLen);
  assign waddr = AW'(base + PRW'(pos_q));
  assign raddr = AW'(base + PRW'(rem_q));

  assign len_sat = (CMW'(len_q) > CMW'(MaxPatternLen)) ? LW'(MaxPatternLen) : LW'(len_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      func_q <= lsp_pkg::func_e'(func_i);
      sidx_q <= style_index_i;
      pos_q  <= char_pos_i;
      chr_q  <= pattern_char_i;
      len_q  <= pattern_length_i;
      fin_q  <= frame_count_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_q  <= '0;
      count_q  <= '0;
      lvalid_q <= '0;
    end else begin
      if (cmd_i.frame_we) frame_q <= fin_q;
      if (cmd_i.len_we) begin
        lvalid_q[sidx_idx] <= 1'b1;
        if (CMW'(sidx_q) >= CMW'(count_q)) count_q <= CW'(CMW'(sidx_q) + CMW'(1));
      end
    end
  end

  lsp_ram #(
    .Width (LW),
    .Depth (NumStyles)
  ) u_len_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.len_we),
    .waddr_i (sidx_idx),
    .wdata_i (len_sat),
    .raddr_i (sidx_idx),
    .rdata_o (len_rdata)
  );

  lsp_ram #(
    .Width (lsp_pkg::CHAR_W),
    .Depth (NumStyles * MaxPatternLen)
  ) u_pat_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.store_we),
    .waddr_i (waddr),
    .wdata_i (chr_q),
    .raddr_i (raddr),
    .rdata_o (chr_rdata)
  );

  // A style never given a length reads as an empty pattern.
  assign plen_d = lvalid_q[sidx_idx] ? len_rdata : '0;

  // Restoring remainder, several frame bits per cycle, most significant first.
  always_comb begin
    logic [LW:0]                 t;
    logic [LW-1:0]               r;
    logic [lsp_pkg::FRAME_W-1:0] s;
    r = rem_q;
    s = shf_q;
    for (int i = 0; i < lsp_pkg::DIV_BITS; i++) begin
      t = {r, s[lsp_pkg::FRAME_W-1]};
      s = s << 1;
      if (t >= {1'b0, plen_q}) t = t - {1'b0, plen_q};
      r = t[LW-1:0];
    end
    rem_step = r;
    shf_step = s;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      plen_q <= plen_d;
      rem_q  <= '0;
      shf_q  <= frame_q;
      step_q <= '0;
    end else if (cmd_i.div_step) begin
      rem_q  <= rem_step;
      shf_q  <= shf_step;
      step_q <= step_q + lsp_pkg::STEP_W'(1);
    end
  end

  assign level_d = cmd_i.res_full ? lsp_pkg::FULL_LEVEL : lsp_pkg::letter_level(chr_rdata);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.res_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_load) begin
      level_q  <= level_d;
      weight_q <= lsp_pkg::level_weight(level_d);
      active_q <= lsp_pkg::ACTIVE_W'(count_q);
    end
  end

  assign stat_o.func      = func_q;
  assign stat_o.sidx_ok   = sidx_ok;
  assign stat_o.pos_ok    = pos_ok;
  assign stat_o.plen_zero = (plen_d == '0);
  assign stat_o.div_last  = (step_q == lsp_pkg::STEP_W'(lsp_pkg::DIV_STEPS - 1));
  assign stat_o.out_free  = out_free;

  assign out_valid_o     = out_valid_q;
  assign style_level_o   = level_q;
  assign style_weight_o  = weight_q;
  assign active_styles_o = active_q;

  a_rem_below_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_step |-> (plen_q != '0) && (rem_q < plen_q))
    else $error("remainder not below pattern length during modulo");

  a_weight_matches_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (weight_q == lsp_pkg::WEIGHT_BASE
                     + lsp_pkg::WEIGHT_STEP * lsp_pkg::WEIGHT_W'(level_q))
                    && (level_q <= lsp_pkg::FULL_LEVEL))
    else $error("result weight does not match level");

  a_store_write_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.store_we |-> sidx_ok && pos_ok)
    else $error("pattern store written outside its style table");

  a_load_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.res_load |-> out_free)
    else $error("result loaded over a word not yet taken");

endmodule

// File: hw/rtl/light_style_pattern_player.sv
// Top level of the light style pattern player: controller plus datapath.
`timescale 1ns / 1ps

// Usage. Each input word carries a function code and its operands. Writing a
// pattern letter, setting a pattern length and setting the frame give no
// result word; a style query gives exactly one result word with the level,
// the drive weight and the active style count, which is one more than the
// highest style index that was given a length. Both channels use valid and
// ready; a word moves when both are high. A non-query word occupies the
// block while it is accepted and then executed. A query with a valid style
// reads the length table, runs the frame modulo length unit (4 frame bits
// per cycle over the 32-bit frame) and then reads the pattern store. An
// empty pattern or an out-of-range style skips the modulo unit. Only one word
// is in flight at a time, so a query holds the input until its result is
// loaded. The result sits in an output register, so the next input word is
// taken while a result waits; should a second query finish while the
// receiver still stalls, the block holds that query until the output
// register frees. Reset clears all lengths (every pattern empty), the frame
// and the style count. The pattern store itself is not cleared, so software
// must write the letters of a pattern before it gives the pattern a length;
// the block itself does not enforce this.
module light_style_pattern_player #(
  parameter int NumStyles     = lsp_pkg::NUM_STYLES,
  parameter int MaxPatternLen = lsp_pkg::MAX_PATTERN_LEN
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [lsp_pkg::FUNC_W-1:0]     func_i,
  input  logic [lsp_pkg::SIDX_W-1:0]     style_index_i,
  input  logic [lsp_pkg::POS_W-1:0]      char_pos_i,
  input  logic [lsp_pkg::CHAR_W-1:0]     pattern_char_i,
  input  logic [lsp_pkg::LEN_W-1:0]      pattern_length_i,
  input  logic [lsp_pkg::FRAME_W-1:0]    frame_count_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [lsp_pkg::LEVEL_W-1:0]    style_level_o,
  output logic [lsp_pkg::WEIGHT_W-1:0]   style_weight_o,
  output logic [lsp_pkg::ACTIVE_W-1:0]   active_styles_o
);

  // Commands flow from the controller, status flows back from the datapath.
  lsp_pkg::cmd_t    cmd;
  lsp_pkg::status_t stat;

  lsp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  lsp_datapath #(
    .NumStyles     (NumStyles),
    .MaxPatternLen (MaxPatternLen)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .func_i           (func_i),
    .style_index_i    (style_index_i),
    .char_pos_i       (char_pos_i),
    .pattern_char_i   (pattern_char_i),
    .pattern_length_i (pattern_length_i),
    .frame_count_i    (frame_count_i),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .style_level_o    (style_level_o),
    .style_weight_o   (style_weight_o),
    .active_styles_o  (active_styles_o)
  );

endmodule
